// File: rtl/twc_pkg.sv
// ----------------------------------------------------------------------------
// twc_pkg: shared types and constants of the two-way cache tag store
// Holds the access kind, the lookup verdict and the fixed field widths.
// ----------------------------------------------------------------------------
package twc_pkg;

    // Width of the cache size register.
    localparam int CFG_W = 4;

    // Cache size after reset: 256 bytes.
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Upper bound on index bits regardless of the store depth.
    localparam int SET_BITS_LIMIT = 12;

    // Address and miss counter widths.
    localparam int ADDR_W = 64;
    localparam int MISS_W = 32;
    localparam logic [MISS_W-1:0] MISS_MAX = '1;

    // Result word: hit, way, evicted dirty, miss count, padded to bytes.
    localparam int OUT_W = 40;

    // Access kind carried on the input side channel.
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_STORE = 1'b1
    } t_cmd;

    // Verdict of one lookup.
    typedef struct packed {
        logic evicted_dirty;
        logic way;
        logic hit;
    } t_lookup;

endpackage

// File: rtl/two_way_cache_tag_lru.sv
// ----------------------------------------------------------------------------
// two_way_cache_tag_lru: tag store of a two-way set-associative cache
// Reports hits and counts misses of a write-back cache with LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry a 64-bit byte address on i_s_tdata and the access kind
//   (load or store) on i_s_tuser. Each accepted word yields exactly one
//   result word on o_m_tdata: hit, way used, evicted-dirty and the running
//   miss count after this access.
//   The set store is one RAM row per set (two tags, two dirty bits, LRU bit).
//   A word is read from the RAM at acceptance, resolved in the next cycle
//   and written back as the result is registered, which raises o_m_tvalid.
//   One word per cycle is sustained while the receiver takes results;
//   an access to the set written in the same cycle takes the forwarded row.
//   After reset the block clears the RAM one set per cycle with o_s_tready
//   low; cache size writes are taken during that pass.
//   When the receiver stalls, one result waits in the output register and one
//   more word can be taken into the lookup stage before o_s_tready drops.
//   Write the cache size register only while no access is in flight; the block does not check.
// ----------------------------------------------------------------------------
module two_way_cache_tag_lru
    import twc_pkg::*;
#(
    parameter int MAX_SETS          = 256,
    parameter int BLOCK_OFFSET_BITS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Cache size register.
    input  logic              i_cfg_wen,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // Access stream.
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [ADDR_W-1:0] i_s_tdata,   // [63:0] address
    input  logic              i_s_tuser,   // [0] command (0 load, 1 store)
    // Result stream.
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata    // [0] hit, [1] way_used,
                                           // [2] evicted_dirty, [34:3] miss_count
);

    localparam int TAG_W        = ADDR_W - BLOCK_OFFSET_BITS;
    localparam int SET_W        = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MAX_SET_BITS = $clog2(MAX_SETS + 1) - 1;
    localparam int ROW_W        = 2 * TAG_W + 3;
    localparam int SB_W         = 4;
    localparam logic [4:0] OFFSET_LOW = 5'(BLOCK_OFFSET_BITS + 1);
    localparam int PAD_W        = OUT_W - MISS_W - 3;

    // Index width for a given cache size.
    function automatic logic [SB_W-1:0] f_set_bits(input logic [CFG_W-1:0] cs);
        logic [4:0] bits;
        bits = ({1'b0, cs} > OFFSET_LOW) ? ({1'b0, cs} - OFFSET_LOW) : 5'd0;
        if (bits > 5'(SET_BITS_LIMIT)) begin
            bits = 5'(SET_BITS_LIMIT);
        end
        if (bits > 5'(MAX_SET_BITS)) begin
            bits = 5'(MAX_SET_BITS);
        end
        return bits[SB_W-1:0];
    endfunction

    logic [SB_W-1:0]  r_set_bits;
    logic             r_clr_busy;
    logic [SET_W-1:0] r_clr_addr;

    logic             r_s1_valid;
    logic [SET_W-1:0] r_s1_set;
    logic [TAG_W-1:0] r_s1_tag;
    t_cmd             r_s1_cmd;
    logic             r_fwd;
    logic [ROW_W-1:0] r_fwd_row;

    logic             r_out_valid;
    t_lookup          r_out_res;
    logic [MISS_W-1:0] r_misses;
    logic [MISS_W-1:0] n_misses;

    logic             accept;
    logic             advance;
    logic [TAG_W-1:0] in_block;
    logic [SET_W-1:0] in_mask;
    logic [SET_W-1:0] in_set;
    logic [TAG_W-1:0] in_tag;

    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] cur_row;
    logic [ROW_W-1:0] new_row;
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;

    logic [TAG_W-1:0] new_tag0;
    logic [TAG_W-1:0] new_tag1;
    logic             new_dirty0;
    logic             new_dirty1;
    logic             new_lru;
    t_lookup          res;

    // Handshake and pipeline flow.
    assign advance    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_clr_busy && (!r_s1_valid || advance);
    assign accept     = i_s_tvalid && o_s_tready;

    // Split the address into set index and tag.
    assign in_block = i_s_tdata[ADDR_W-1:BLOCK_OFFSET_BITS];
    assign in_mask  = (SET_W'(1) << r_set_bits) - SET_W'(1);
    assign in_set   = in_block[SET_W-1:0] & in_mask;
    assign in_tag   = in_block >> r_set_bits;

    // Cache geometry, derived at reset and whenever the size register is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= f_set_bits(CFG_RESET);
        end else if (i_cfg_wen) begin
            r_set_bits <= f_set_bits(i_cfg_wdata);
        end
    end

    // Clearing pass over the set store after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == SET_W'(MAX_SETS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + SET_W'(1);
            end
        end
    end

    // Set store: one row per set.
    assign ram_we    = r_clr_busy || advance;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_set;
    assign ram_wdata = r_clr_busy ? '0 : new_row;

    twc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    // Lookup stage registers; the forward flag marks a read that raced a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_fwd      <= advance && (r_s1_set == in_set);
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_set  <= in_set;
            r_s1_tag  <= in_tag;
            r_s1_cmd  <= t_cmd'(i_s_tuser);
            r_fwd_row <= new_row;
        end
    end

    // Current row of the set, with forwarding of the write just made.
    assign cur_row = r_fwd ? r_fwd_row : ram_rdata;

    twc_lookup #(
        .TAG_W (TAG_W)
    ) u_lookup (
        .i_tag    (r_s1_tag),
        .i_cmd    (r_s1_cmd),
        .i_tag0   (cur_row[TAG_W-1:0]),
        .i_tag1   (cur_row[2*TAG_W-1:TAG_W]),
        .i_dirty0 (cur_row[2*TAG_W]),
        .i_dirty1 (cur_row[2*TAG_W+1]),
        .i_lru    (cur_row[2*TAG_W+2]),
        .o_tag0   (new_tag0),
        .o_tag1   (new_tag1),
        .o_dirty0 (new_dirty0),
        .o_dirty1 (new_dirty1),
        .o_lru    (new_lru),
        .o_res    (res)
    );

    assign new_row = {new_lru, new_dirty1, new_dirty0, new_tag1, new_tag0};

    // Saturating miss counter.
    assign n_misses = (!res.hit && (r_misses != MISS_MAX)) ? r_misses + MISS_W'(1)
                                                           : r_misses;

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_misses    <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_misses    <= n_misses;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_misses, r_out_res.evicted_dirty,
                         r_out_res.way, r_out_res.hit};

endmodule

// File: rtl/twc_ram.sv
// ----------------------------------------------------------------------------
// twc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module twc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; returns the old contents on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/twc_lookup.sv
// ----------------------------------------------------------------------------
// twc_lookup: tag compare and set update for one access
// Compares the tag against both ways, picks the way and builds the new set.
// ----------------------------------------------------------------------------
module twc_lookup
    import twc_pkg::*;
#(
    parameter int TAG_W = 58
) (
    input  logic [TAG_W-1:0] i_tag,
    input  t_cmd             i_cmd,
    input  logic [TAG_W-1:0] i_tag0,
    input  logic [TAG_W-1:0] i_tag1,
    input  logic             i_dirty0,
    input  logic             i_dirty1,
    input  logic             i_lru,
    output logic [TAG_W-1:0] o_tag0,
    output logic [TAG_W-1:0] o_tag1,
    output logic             o_dirty0,
    output logic             o_dirty1,
    output logic             o_lru,
    output t_lookup          o_res
);

    logic match0;
    logic match1;
    logic hit;
    logic way;
    logic store;

    assign store  = (i_cmd == CMD_STORE);
    assign match0 = (i_tag0 == i_tag);
    assign match1 = (i_tag1 == i_tag);
    assign hit    = match0 | match1;

    // Way 1 wins when both ways match; a miss takes the LRU victim.
    assign way = hit ? match1 : i_lru;

    // Verdict: the victim's dirty bit only matters on a miss.
    always_comb begin
        o_res.hit           = hit;
        o_res.way           = way;
        o_res.evicted_dirty = (!hit) && (way ? i_dirty1 : i_dirty0);
    end

    // New set contents: refill on a miss, mark dirty on a store hit.
    always_comb begin
        o_tag0   = i_tag0;
        o_tag1   = i_tag1;
        o_dirty0 = i_dirty0;
        o_dirty1 = i_dirty1;
        if (way) begin
            if (!hit) begin
                o_tag1   = i_tag;
                o_dirty1 = store;
            end else begin
                o_dirty1 = i_dirty1 | store;
            end
        end else begin
            if (!hit) begin
                o_tag0   = i_tag;
                o_dirty0 = store;
            end else begin
                o_dirty0 = i_dirty0 | store;
            end
        end
        o_lru = ~way;
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-way cache tag store
// Streams loads and stores into the block in bursts while the result side
// stalls on its own pattern. A shadow copy of the tags, dirty bits, LRU bits
// and miss counter predicts each result word, which is compared field by
// field. The cache size is changed between phases, from one set up to the
// largest size, without clearing the stored tags.
// ----------------------------------------------------------------------------
module testbench;
    import twc_pkg::*;

    localparam int MAX_SETS    = 256;
    localparam int OFFSET_BITS = 6;
    localparam int TAG_W       = ADDR_W - OFFSET_BITS;
    localparam int PHASE_WORDS = 105;
    localparam int NUM_ROWS    = 19;

    // Miss count above the lookup verdict, as packed in the result word.
    typedef struct packed {
        logic [MISS_W-1:0] miss;
        t_lookup           look;
    } t_access_result;

    // One directed access; the result is typed in only when given is set.
    typedef struct packed {
        t_cmd                cmd;
        logic [ADDR_W-1:0]   addr;
        logic                given;
        t_access_result      want;
    } t_stim_row;

    // Directed accesses at the reset size of two sets. Right after reset
    // every tag is zero, so the first accesses hit in way 1.
    localparam t_stim_row DIR_ROWS [NUM_ROWS] = '{
        '{CMD_LOAD,  64'h0000_0000_0000_0000, 1'b1, '{32'd0, '{1'b0, 1'b1, 1'b1}}},
        '{CMD_STORE, 64'h0000_0000_0000_003F, 1'b1, '{32'd0, '{1'b0, 1'b1, 1'b1}}},
        '{CMD_LOAD,  64'h0000_0000_0000_0040, 1'b1, '{32'd0, '{1'b0, 1'b1, 1'b1}}},
        '{CMD_STORE, 64'h0000_0000_0000_0080, 1'b0, '0},
        '{CMD_STORE, 64'h0000_0000_0000_0100, 1'b0, '0},
        '{CMD_LOAD,  64'h0000_0000_0000_0080, 1'b0, '0},
        '{CMD_LOAD,  64'h0000_0000_0000_0180, 1'b0, '0},
        '{CMD_LOAD,  64'h0000_0000_0000_0100, 1'b0, '0},
        '{CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{CMD_LOAD,  64'hFFFF_FFFF_FFFF_FFC0, 1'b0, '0},
        '{CMD_STORE, 64'h8000_0000_0000_0000, 1'b0, '0},
        '{CMD_LOAD,  64'h5555_5555_5555_5555, 1'b0, '0},
        '{CMD_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{CMD_LOAD,  64'h0000_0000_0000_0040, 1'b0, '0},
        '{CMD_STORE, 64'h0000_0000_0000_00C0, 1'b0, '0},
        '{CMD_STORE, 64'h0000_0000_0000_0140, 1'b0, '0},
        '{CMD_LOAD,  64'h0000_0000_0000_0040, 1'b0, '0},
        '{CMD_STORE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{CMD_LOAD,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0}
    };

    // Cache sizes of the random phases; the last phase picks one at random.
    localparam logic [CFG_W-1:0] SIZE_PLAN [5] = '{4'd15, 4'd7, 4'd0, 4'd12, 4'd9};

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_wen   = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [ADDR_W-1:0] i_s_tdata   = '0;   // [63:0] address
    logic              i_s_tuser   = 1'b0; // [0] command (0 load, 1 store)
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;          // [0] hit, [1] way_used,
                                           // [2] evicted_dirty, [34:3] miss_count

    // Shadow copy of the cache state.
    logic [TAG_W-1:0]  tag_mem   [2*MAX_SETS];
    logic              dirty_mem [2*MAX_SETS];
    logic              lru_mem   [MAX_SETS];
    logic [MISS_W-1:0] miss_total;
    logic [CFG_W-1:0]  size_log2;

    t_access_result pending_results [$];
    int             fail_count  = 0;
    int unsigned    stall_count = 0;
    int unsigned    stall_mode  = 0;

    two_way_cache_tag_lru #(
        .MAX_SETS          (MAX_SETS),
        .BLOCK_OFFSET_BITS (OFFSET_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Number of index bits for a given cache size, capped by the store depth.
    function automatic int unsigned set_bits_of(logic [CFG_W-1:0] cs);
        int unsigned bits;
        bits = (cs > OFFSET_BITS + 1) ? cs - (OFFSET_BITS + 1) : 0;
        if (bits > SET_BITS_LIMIT) begin
            bits = SET_BITS_LIMIT;
        end
        while (bits > 0 && (1 << bits) > MAX_SETS) begin
            bits--;
        end
        return bits;
    endfunction

    // Looks up one access in the shadow state, updates it and returns the
    // result word the block should produce.
    function automatic t_access_result lookup_access(t_cmd cmd, logic [ADDR_W-1:0] addr);
        int unsigned    sb;
        int unsigned    set_idx;
        int unsigned    slot;
        logic [TAG_W-1:0] blk;
        logic [TAG_W-1:0] tag;
        t_access_result res;
        sb      = set_bits_of(size_log2);
        blk     = addr[ADDR_W-1:OFFSET_BITS];
        set_idx = int'(blk[SET_BITS_LIMIT-1:0]) & ((1 << sb) - 1);
        tag     = blk >> sb;
        res     = '0;
        // Way 1 wins when both ways hold the tag.
        if (tag_mem[2*set_idx] == tag) begin
            res.look.hit = 1'b1;
            res.look.way = 1'b0;
        end
        if (tag_mem[2*set_idx+1] == tag) begin
            res.look.hit = 1'b1;
            res.look.way = 1'b1;
        end
        if (res.look.hit) begin
            slot = 2*set_idx + res.look.way;
            if (cmd == CMD_STORE) begin
                dirty_mem[slot] = 1'b1;
            end
        end else begin
            // Refill the least recently used way.
            res.look.way           = lru_mem[set_idx];
            slot                   = 2*set_idx + res.look.way;
            res.look.evicted_dirty = dirty_mem[slot];
            tag_mem[slot]          = tag;
            dirty_mem[slot]        = (cmd == CMD_STORE);
            if (miss_total != MISS_MAX) begin
                miss_total = miss_total + 1'b1;
            end
        end
        lru_mem[set_idx] = ~res.look.way;
        res.miss = miss_total;
        return res;
    endfunction

    // Presents one access word, waits for it to be taken and queues the
    // expected result. The valid stays high; the caller lowers it on a gap.
    task automatic send_access(t_cmd cmd, logic [ADDR_W-1:0] addr, logic given,
                               t_access_result want);
        t_access_result res;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= addr;
        do @(posedge i_clk); while (!o_s_tready);
        res = lookup_access(cmd, addr);
        pending_results.push_back(given ? want : res);
    endtask

    // Result side: stall pattern and field-by-field check.
    always @(posedge i_clk) begin
        t_access_result got;
        t_access_result exp;
        stall_count <= stall_count + 1;
        if (stall_count % 64 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: begin
                i_m_tready <= 1'b1;
            end
            1: begin
                i_m_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                i_m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                i_m_tready <= (stall_count[2:1] != 2'b11);
            end
        endcase

        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[$bits(t_access_result)-1:0];
            if (pending_results.size() == 0) begin
                $display("%0t: result word with nothing expected: %h", $time, o_m_tdata);
                fail_count++;
            end else begin
                exp = pending_results.pop_front();
                if (got.look.hit !== exp.look.hit) begin
                    $display("%0t: hit expected %0d got %0d",
                             $time, exp.look.hit, got.look.hit);
                    fail_count++;
                end
                if (got.look.way !== exp.look.way) begin
                    $display("%0t: way_used expected %0d got %0d",
                             $time, exp.look.way, got.look.way);
                    fail_count++;
                end
                if (got.look.evicted_dirty !== exp.look.evicted_dirty) begin
                    $display("%0t: evicted_dirty expected %0d got %0d",
                             $time, exp.look.evicted_dirty, got.look.evicted_dirty);
                    fail_count++;
                end
                if (got.miss !== exp.miss) begin
                    $display("%0t: miss_count expected %0d got %0d",
                             $time, exp.miss, got.miss);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus.
    initial begin
        logic [CFG_W-1:0]  size_val;
        logic [TAG_W-1:0]  tag_pool [6];
        logic [ADDR_W-1:0] addr;
        int unsigned       sb;
        int                words_left;
        int                burst;
        int                gap;

        for (int i = 0; i < 2*MAX_SETS; i++) begin
            tag_mem[i]   = '0;
            dirty_mem[i] = 1'b0;
        end
        for (int i = 0; i < MAX_SETS; i++) begin
            lru_mem[i] = 1'b0;
        end
        miss_total = '0;
        size_log2  = CFG_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed accesses, back to back to exercise same-set forwarding.
        for (int r = 0; r < NUM_ROWS; r++) begin
            send_access(DIR_ROWS[r].cmd, DIR_ROWS[r].addr, DIR_ROWS[r].given,
                        DIR_ROWS[r].want);
        end
        i_s_tvalid <= 1'b0;

        for (int p = 0; p < 6; p++) begin
            // Change the cache size only with nothing in flight.
            while (pending_results.size() != 0) begin
                @(posedge i_clk);
            end
            repeat (3) @(posedge i_clk);
            size_val    = (p < 5) ? SIZE_PLAN[p] : CFG_W'($urandom_range(0, 15));
            i_cfg_wen   <= 1'b1;
            i_cfg_wdata <= size_val;
            @(posedge i_clk);
            i_cfg_wen <= 1'b0;
            size_log2 = size_val;
            sb        = set_bits_of(size_log2);

            // A few tags per phase so that sets see both hits and evictions.
            tag_pool[0] = '0;
            tag_pool[1] = TAG_W'(1);
            tag_pool[2] = TAG_W'($urandom_range(2, 7));
            tag_pool[3] = '1;
            tag_pool[4] = TAG_W'({$urandom, $urandom});
            tag_pool[5] = TAG_W'({$urandom, $urandom});

            words_left = PHASE_WORDS;
            while (words_left > 0) begin
                burst = $urandom_range(1, 24);
                if (burst > words_left) begin
                    burst = words_left;
                end
                for (int b = 0; b < burst; b++) begin
                    if ($urandom_range(0, 99) < 12) begin
                        addr = {$urandom, $urandom};
                    end else begin
                        addr = (ADDR_W'(tag_pool[$urandom_range(0, 5)]) << (OFFSET_BITS + sb))
                             | (ADDR_W'($urandom_range(0, (1 << sb) - 1)) << OFFSET_BITS)
                             | ADDR_W'($urandom_range(0, (1 << OFFSET_BITS) - 1));
                    end
                    send_access(t_cmd'($urandom_range(0, 1)), addr, 1'b0, '0);
                end
                words_left -= burst;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_s_tvalid <= 1'b0;
        end

        // Drain and let the pipeline settle.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[two_way_cache_tag_lru] OK");
        end else begin
            $display("[two_way_cache_tag_lru] ERROR");
        end
        $finish;
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("[two_way_cache_tag_lru] ERROR");
        $finish;
    end

endmodule
